// ----- design/gbpe_pkg.sv -----
// Shared types and constants for the glyph bitmap pixel expander.
// No dependencies; imported by gbpe_emit and glyph_bitmap_pixel_expander.
`default_nettype none

package gbpe_pkg;

	localparam int BYTE_BITS       = 8;
	localparam int MAX_GLYPH_WIDTH = 128;
	// Width used for all glyph-width arithmetic: holds any width up to 256.
	localparam int WIDE_W          = 9;
	localparam int X_W             = 9;
	localparam int Y_W             = 10;
	localparam int SHADE_W         = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 8;
	localparam logic [Y_W-1:0] ROW_MAX = {Y_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 2'd0,
		REG_ORIGIN_Y    = 2'd1,
		REG_ROW_WIDTH   = 2'd2,
		REG_PIXEL_COLOR = 2'd3
	} cfg_reg_t;

	// One byte's work, ready for emission: the bits to draw (MSB is the
	// leftmost pixel), the screen column of the MSB, the row and the shade.
	typedef struct packed {
		logic [BYTE_BITS-1:0] mask;
		logic [X_W-1:0]       base_x;
		logic [Y_W-1:0]       pos_y;
		logic [SHADE_W-1:0]   shade;
	} gbpe_item_t;

endpackage

`default_nettype wire

// ----- design/gbpe_emit.sv -----
// Pixel emitter: holds one byte's pixel mask and sends one pixel word a cycle while out_ready allows.
// Depends on gbpe_pkg for the item struct and field widths.
`default_nettype none

module gbpe_emit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire gbpe_pkg::gbpe_item_t       item,
	input  wire logic                       item_valid,
	output logic                            item_ready,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [gbpe_pkg::X_W-1:0]        pixel_x,
	output logic [gbpe_pkg::Y_W-1:0]        pixel_y,
	output logic [gbpe_pkg::SHADE_W-1:0]    pixel_shade,
	output logic                            last_of_byte
);
	import gbpe_pkg::*;

	gbpe_item_t           item_s1;
	logic                 valid_s1;
	logic [2:0]           lead_idx;
	logic [BYTE_BITS-1:0] rest_mask;
	logic                 has_pixel;
	logic                 out_load;
	logic                 s1_done;

	logic                 out_valid_q;
	logic [X_W-1:0]       pixel_x_q;
	logic [Y_W-1:0]       pixel_y_q;
	logic [SHADE_W-1:0]   pixel_shade_q;
	logic                 last_of_byte_q;

	// Leftmost set bit; the loop runs from the right so the leftmost wins.
	always_comb begin
		lead_idx = 3'd0;
		for (int k = BYTE_BITS - 1; k >= 0; k--) begin
			if (item_s1.mask[BYTE_BITS-1-k]) begin
				lead_idx = 3'(k);
			end
		end
		rest_mask = item_s1.mask & ~(8'h80 >> lead_idx);
	end

	assign has_pixel  = |item_s1.mask;
	assign out_load   = valid_s1 && has_pixel && (!out_valid_q || out_ready);
	assign s1_done    = valid_s1 && (!has_pixel || (out_load && (rest_mask == '0)));
	assign item_ready = !valid_s1 || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end else if (out_load) begin
			item_s1.mask <= rest_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_x_q      <= item_s1.base_x + X_W'(lead_idx);
			pixel_y_q      <= item_s1.pos_y;
			pixel_shade_q  <= item_s1.shade;
			last_of_byte_q <= (rest_mask == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign pixel_shade  = pixel_shade_q;
	assign last_of_byte = last_of_byte_q;

endmodule

`default_nettype wire

// ----- design/glyph_bitmap_pixel_expander.sv -----
// Glyph bitmap pixel expander, 1 bit per pixel. Feed the glyph one byte word
// at a time, MSB first = leftmost pixel; each set bit comes out as one pixel
// word (screen x, screen y, shade), with last_of_byte flagging the final pixel
// of its byte. A row ends when the column reaches row_width; the rest of that
// byte is dropped. A byte with last_byte set clears the position after its
// pixels. Rate: a byte word is taken every cycle as long as each byte carries
// at most one set pixel and out_ready stays high; otherwise a byte holds the
// emitter until its last pixel is sent, as the single output register sends
// one pixel a cycle while out_ready allows. Bytes with no set pixels produce
// nothing. Write the configuration registers only while idle. Depends on
// gbpe_pkg and gbpe_emit.
`default_nettype none

module glyph_bitmap_pixel_expander #(
	parameter int MAX_GLYPH_WIDTH = gbpe_pkg::MAX_GLYPH_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write channel
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gbpe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gbpe_pkg::CFG_DATA_W-1:0] cfg_data,
	// bitmap byte words in
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [gbpe_pkg::BYTE_BITS-1:0]  bitmap_byte,
	input  wire logic                          last_byte,
	// pixel words out
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gbpe_pkg::X_W-1:0]           pixel_x,
	output logic [gbpe_pkg::Y_W-1:0]           pixel_y,
	output logic [gbpe_pkg::SHADE_W-1:0]       pixel_shade,
	output logic                               last_of_byte
);
	import gbpe_pkg::*;

	// Column counter holds 0 .. MAX_GLYPH_WIDTH-1.
	localparam int COL_W = $clog2(MAX_GLYPH_WIDTH);
	localparam logic [WIDE_W-1:0] WIDTH_LIMIT = WIDE_W'(MAX_GLYPH_WIDTH);

	logic [7:0]         origin_x_q;
	logic [7:0]         origin_y_q;
	logic [7:0]         row_width_q;
	logic [SHADE_W-1:0] pixel_color_q;

	logic [COL_W-1:0]   col_q;
	logic [Y_W-1:0]     row_q;

	logic [WIDE_W-1:0]  width_eff;
	logic [WIDE_W-1:0]  col_wide;
	logic [WIDE_W-1:0]  bits_left;
	logic [3:0]         bits_used;
	logic               row_wrap;
	logic [Y_W:0]       y_sum;
	gbpe_item_t         item;
	logic               in_take;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			row_width_q   <= 8'd8;
			pixel_color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:    origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:    origin_y_q    <= cfg_data;
				REG_ROW_WIDTH:   row_width_q   <= cfg_data;
				REG_PIXEL_COLOR: pixel_color_q <= cfg_data[SHADE_W-1:0];
				default: ;
			endcase
		end
	end

	// Width zero acts as one; widths above the limit clamp to it.
	always_comb begin
		width_eff = WIDE_W'(row_width_q);
		if (width_eff == '0) begin
			width_eff = WIDE_W'(1);
		end
		if (width_eff > WIDTH_LIMIT) begin
			width_eff = WIDTH_LIMIT;
		end
	end

	// Bits of this byte that fall inside the row. A column already at or past
	// the width still consumes one bit before the row wraps.
	always_comb begin
		col_wide  = WIDE_W'(col_q);
		bits_left = (width_eff > col_wide) ? (width_eff - col_wide) : WIDE_W'(1);
		row_wrap  = (bits_left <= WIDE_W'(BYTE_BITS));
		bits_used = row_wrap ? bits_left[3:0] : 4'(BYTE_BITS);
	end

	// Saturate the screen row at its top value.
	assign y_sum = (Y_W+1)'(origin_y_q) + (Y_W+1)'(row_q);

	always_comb begin
		item.mask   = bitmap_byte & ~(8'hFF >> bits_used);
		item.base_x = X_W'(origin_x_q) + X_W'(col_q);
		item.pos_y  = y_sum[Y_W] ? ROW_MAX : y_sum[Y_W-1:0];
		item.shade  = pixel_color_q;
	end

	assign in_take = in_valid && in_ready;

	// Position counters advance as each byte word is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_take) begin
			if (last_byte) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_wrap) begin
				col_q <= '0;
				if (row_q != ROW_MAX) begin
					row_q <= row_q + Y_W'(1);
				end
			end else begin
				col_q <= COL_W'(col_wide + WIDE_W'(BYTE_BITS));
			end
		end
	end

	gbpe_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (in_valid),
		.item_ready   (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_shade  (pixel_shade),
		.last_of_byte (last_of_byte)
	);

endmodule

`default_nettype wire

// ----- tb/glyph_bitmap_pixel_expander_tb.sv -----
// Self-checking testbench for glyph_bitmap_pixel_expander: a directed table, then random
// glyphs under random configurations, checked word by word against a local pixel predictor.
// Depends on gbpe_pkg and the glyph_bitmap_pixel_expander RTL.
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander_tb;
	import gbpe_pkg::*;

	// Quiet cycles (no word moving on any channel) before the run is declared hung.
	localparam int HANG_LIMIT  = 300;
	// Settle time after the last expected pixel; covers bytes that emit nothing.
	localparam int SETTLE_CYC  = 12;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_BYTES = 25;

	typedef struct packed {
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic [SHADE_W-1:0] shade;
		logic               lob;
	} pixel_t;

	// One row of the directed table: a register write or a byte word, with a
	// hand-written expected pixel where the answer is obvious.
	typedef struct {
		bit                    is_cfg;
		cfg_reg_t              idx;
		logic [BYTE_BITS-1:0]  data;
		logic                  last;
		bit                    typed;
		pixel_t                px;
	} step_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [BYTE_BITS-1:0]  bitmap_byte;
	logic                  last_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [X_W-1:0]        pixel_x;
	logic [Y_W-1:0]        pixel_y;
	logic [SHADE_W-1:0]    pixel_shade;
	logic                  last_of_byte;

	glyph_bitmap_pixel_expander dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.bitmap_byte  (bitmap_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_shade  (pixel_shade),
		.last_of_byte (last_of_byte)
	);

	// Predictor copy of the registers and the scan position.
	int reg_ox;
	int reg_oy;
	int reg_width;
	logic [SHADE_W-1:0] reg_color;
	int col_ofs;
	int row_ofs;

	pixel_t pixel_q[$];   // pixels owed by the block, oldest first
	step_t  plan[$];

	int errors      = 0;
	int bytes_sent  = 0;
	int pixels_seen = 0;
	int reg_writes  = 0;
	int burst_left  = 0;
	int quiet_cyc   = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clamp the programmed width the way the block does: zero acts as one,
	// anything past the maximum glyph width acts as the maximum.
	function automatic int glyph_width();
		int w;
		w = (reg_width == 0) ? 1 : reg_width;
		if (w > MAX_GLYPH_WIDTH)
			w = MAX_GLYPH_WIDTH;
		return w;
	endfunction

	// Scan one byte MSB first, advance the position and, when keep is set,
	// queue the pixels it draws. The rest of the byte is dropped once the
	// row fills; a last byte clears the position after its pixels.
	task automatic expand_byte(input logic [BYTE_BITS-1:0] b, input logic lst, input bit keep);
		int w;
		int k;
		int cnt;
		int sx;
		int sy;
		pixel_t pend[BYTE_BITS];
		begin
			w = glyph_width();
			cnt = 0;
			for (k = 0; k < BYTE_BITS; k++) begin
				if (b[BYTE_BITS-1-k]) begin
					sx = reg_ox + col_ofs;
					sy = reg_oy + row_ofs;
					if (sy > int'(ROW_MAX))
						sy = int'(ROW_MAX);
					pend[cnt].x = sx[X_W-1:0];
					pend[cnt].y = sy[Y_W-1:0];
					pend[cnt].shade = reg_color;
					pend[cnt].lob = 1'b0;
					cnt++;
				end
				col_ofs++;
				if (col_ofs >= w) begin
					col_ofs = 0;
					if (row_ofs < int'(ROW_MAX))
						row_ofs++;
					break;
				end
			end
			if (keep)
				for (k = 0; k < cnt; k++) begin
					pend[k].lob = (k == cnt - 1);
					pixel_q.push_back(pend[k]);
				end
			if (lst) begin
				col_ofs = 0;
				row_ofs = 0;
			end
		end
	endtask

	// Offer one byte word. The sender runs in bursts; at the end of a burst
	// it may drop valid for a random gap. Valid stays high between back-to-back words.
	task automatic send_word(input logic [BYTE_BITS-1:0] b, input logic lst, input bit keep);
		int gap;
		begin
			gap = 0;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
				gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9);
			end
			burst_left--;
			@(negedge clk);
			if (gap > 0) begin
				in_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid = 1'b1;
			bitmap_byte = b;
			last_byte = lst;
			do @(posedge clk); while (!in_ready);
			bytes_sent++;
			expand_byte(b, lst, keep);
		end
	endtask

	// Drop the input, wait for every owed pixel, then let the pipe settle so
	// a byte that draws nothing cannot still be in flight.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pixel_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_ORIGIN_X:    reg_ox = int'(val);
			REG_ORIGIN_Y:    reg_oy = int'(val);
			REG_ROW_WIDTH:   reg_width = int'(val);
			REG_PIXEL_COLOR: reg_color = val[SHADE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_all(input logic [7:0] ox, input logic [7:0] oy, input logic [7:0] w,
		input logic [7:0] color);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_PIXEL_COLOR, color);
	endtask

	// Byte contents: mostly random, with empty and full bytes mixed in.
	function automatic logic [BYTE_BITS-1:0] rand_bits();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic step_t row_cfg(input cfg_reg_t idx, input logic [7:0] val);
		step_t s;
		s = '{is_cfg: 1'b1, idx: idx, data: val, last: 1'b0, typed: 1'b0, px: '0};
		return s;
	endfunction

	function automatic step_t row_byte(input logic [7:0] b, input logic lst);
		step_t s;
		s = '{is_cfg: 1'b0, idx: REG_ORIGIN_X, data: b, last: lst, typed: 1'b0, px: '0};
		return s;
	endfunction

	// A byte known to draw exactly one pixel at the given spot.
	function automatic step_t row_typed(input logic [7:0] b, input logic lst, input int x,
		input int y, input int shade);
		step_t s;
		s = row_byte(b, lst);
		s.typed = 1'b1;
		s.px = '{x: x[X_W-1:0], y: y[Y_W-1:0], shade: shade[SHADE_W-1:0], lob: 1'b1};
		return s;
	endfunction

	// Receiver: stall on a rotating 16-bit pattern that is reloaded now and again.
	// Some reloads are all-ready so long stretches go through without stalls;
	// in the others bits 0 and 8 are forced ready, which bounds any stall run.
	initial begin
		logic [15:0] pat;
		logic [31:0] r;
		int n;
		out_ready = 1'b0;
		pat = 16'hFFFF;
		n = 0;
		forever begin
			@(negedge clk);
			if (n % 64 == 0) begin
				r = $urandom;
				pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (r[15:0] | 16'h0101);
			end
			out_ready = pat[n % 16];
			n++;
		end
	end

	// Check each pixel word against the oldest owed pixel.
	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			pixels_seen++;
			if (pixel_q.size() == 0) begin
				errors++;
				$display("%0t: pixel word with none owed: x=%0d y=%0d shade=%0d last=%0b",
					$time, pixel_x, pixel_y, pixel_shade, last_of_byte);
			end else begin
				want = pixel_q.pop_front();
				if (pixel_x !== want.x) begin
					errors++;
					$display("%0t: pixel_x expected %0d, got %0d", $time, want.x, pixel_x);
				end
				if (pixel_y !== want.y) begin
					errors++;
					$display("%0t: pixel_y expected %0d, got %0d", $time, want.y, pixel_y);
				end
				if (pixel_shade !== want.shade) begin
					errors++;
					$display("%0t: pixel_shade expected %0d, got %0d", $time, want.shade,
						pixel_shade);
				end
				if (last_of_byte !== want.lob) begin
					errors++;
					$display("%0t: last_of_byte expected %0b, got %0b", $time, want.lob,
						last_of_byte);
				end
			end
		end
	end

	// Watchdog: end the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (cfg_valid && cfg_ready) || (out_valid && out_ready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= HANG_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d pixels still owed",
					$time, quiet_cyc, pixel_q.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int i;
		int p;
		int n;
		int k;
		int glen;

		// Hold every input at a known value through reset.
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		bitmap_byte = '0;
		last_byte = 1'b0;
		reg_ox = 0;
		reg_oy = 0;
		reg_width = 8;
		reg_color = '0;
		col_ofs = 0;
		row_ofs = 0;

		// Directed table. Reset defaults first: origin 0, width 8, shade 0.
		plan.push_back(row_typed(8'h80, 1'b0, 0, 0, 0));
		// The low bit lands on the last column of the row, then the glyph ends.
		plan.push_back(row_byte(8'h01, 1'b1));
		// Far corner, oversized width (clamps to the maximum), brightest shade.
		plan.push_back(row_cfg(REG_ORIGIN_X, 8'd255));
		plan.push_back(row_cfg(REG_ORIGIN_Y, 8'd255));
		plan.push_back(row_cfg(REG_ROW_WIDTH, 8'd255));
		plan.push_back(row_cfg(REG_PIXEL_COLOR, 8'd3));
		plan.push_back(row_typed(8'h80, 1'b1, 255, 255, 3));
		plan.push_back(row_byte(8'hFF, 1'b0));
		plan.push_back(row_byte(8'h00, 1'b0));
		plan.push_back(row_byte(8'hFF, 1'b0));
		plan.push_back(row_byte(8'h5A, 1'b1));
		// Width zero behaves as one pixel per row.
		plan.push_back(row_cfg(REG_ROW_WIDTH, 8'd0));
		plan.push_back(row_cfg(REG_ORIGIN_X, 8'd0));
		plan.push_back(row_cfg(REG_ORIGIN_Y, 8'd0));
		plan.push_back(row_cfg(REG_PIXEL_COLOR, 8'd1));
		plan.push_back(row_typed(8'hFF, 1'b0, 0, 0, 1));
		plan.push_back(row_byte(8'h7F, 1'b0));
		plan.push_back(row_typed(8'hC3, 1'b1, 0, 2, 1));
		// Narrow rows that split bytes.
		plan.push_back(row_cfg(REG_ROW_WIDTH, 8'd3));
		plan.push_back(row_cfg(REG_PIXEL_COLOR, 8'd2));
		plan.push_back(row_byte(8'hFF, 1'b0));
		plan.push_back(row_byte(8'h00, 1'b0));
		plan.push_back(row_byte(8'hE0, 1'b1));
		// Maximum width exactly.
		plan.push_back(row_cfg(REG_ROW_WIDTH, 8'd128));
		plan.push_back(row_cfg(REG_PIXEL_COLOR, 8'd0));
		plan.push_back(row_cfg(REG_ORIGIN_X, 8'd128));
		plan.push_back(row_byte(8'hA5, 1'b0));
		plan.push_back(row_byte(8'h3C, 1'b0));
		plan.push_back(row_byte(8'hFF, 1'b1));
		plan.push_back(row_cfg(REG_ROW_WIDTH, 8'd1));
		plan.push_back(row_typed(8'h80, 1'b0, 128, 0, 0));
		plan.push_back(row_byte(8'h01, 1'b1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the table; registers change only once the block is idle.
		for (i = 0; i < plan.size(); i++) begin
			if (plan[i].is_cfg) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else if (plan[i].typed) begin
				send_word(plan[i].data, plan[i].last, 1'b0);
				pixel_q.push_back(plan[i].px);
			end else begin
				send_word(plan[i].data, plan[i].last, 1'b1);
			end
		end

		// Random phases: extremes first, then random settings biased toward
		// narrow glyphs. Mostly whole glyphs, some stray bytes with a random
		// end flag to break the row structure.
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: set_all(8'd0, 8'd0, 8'd1, 8'd0);
				1: set_all(8'd255, 8'd255, 8'd128, 8'd3);
				2: set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd255,
					8'($urandom_range(0, 255)));
				3: set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0,
					8'($urandom_range(0, 255)));
				default: set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(1, 20)),
					8'($urandom_range(0, 255)));
			endcase
			n = 0;
			while (n < PHASE_BYTES) begin
				if ($urandom_range(0, 9) < 8) begin
					glen = int'($urandom_range(1, 3)) * ((glyph_width() + 7) / 8);
					if (glen > PHASE_BYTES - n)
						glen = PHASE_BYTES - n;
					for (k = 0; k < glen; k++) begin
						send_word(rand_bits(), k == glen - 1, 1'b1);
						n++;
					end
				end else begin
					send_word(rand_bits(), 1'($urandom_range(0, 1)), 1'b1);
					n++;
				end
			end
		end

		drain();
		$display("Sent %0d byte words and %0d register writes; checked %0d pixel words.",
			bytes_sent, reg_writes, pixels_seen);
		$display("Covered width clamps, edge origins, skipped row tails and glyph restarts.");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
